// ----- rtl/sliding_window_anagram_match_defines.svh -----
// Assertion macros used by the checker of the anagram search block.
`ifndef SLIDING_WINDOW_ANAGRAM_MATCH_DEFINES_SVH
`define SLIDING_WINDOW_ANAGRAM_MATCH_DEFINES_SVH

// Same-cycle implication, quiet while reset is high.
`define SWAM_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, quiet while reset is high.
`define SWAM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is also checked across reset.
`define SWAM_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/swam_pkg.sv -----
// Shared constants, opcodes and stage control type of the anagram search block.
package swam_pkg;

   // Default capacity and alphabet size.
   localparam int MAX_PATTERN_DEF = 4096;
   localparam int ALPHABET_DEF    = 26;

   // Code of the first letter of the alphabet ('a').
   localparam int LETTER_BASE = 97;

   // Opcodes of an input word.
   localparam logic [1:0] OP_CLEAR   = 2'd0;
   localparam logic [1:0] OP_PATTERN = 2'd1;
   localparam logic [1:0] OP_TEXT    = 2'd2;

   // Control bits handed from the front stage to the count update stage.
   typedef struct packed {
      logic clear;     // return counts and found flag to zero
      logic pat_add;   // add the letter to the pattern counts
      logic text;      // text word, produces a result word
      logic keep;      // text letter enters the window
      logic remove;    // oldest window letter leaves
      logic full;      // window holds a whole pattern length after this word
      logic last;      // echo of the last bit
      logic overflow;  // pattern overflow flag seen by this word
   } swam_ctl_type;

endpackage

// ----- rtl/swam_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered, read-first output.
module swam_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // A read at the address being written returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/swam_front.sv -----
// Front stage: decodes a word, keeps lengths and the ring pointer, drives the letter ring.
module swam_front #(
   parameter int MAX_PATTERN = swam_pkg::MAX_PATTERN_DEF,
   parameter int ALPHABET    = swam_pkg::ALPHABET_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  logic [1:0]                         opcode,
   input  logic [6:0]                         letter,
   input  logic                               last,
   input  logic                               advance,
   output logic                               s1_valid,
   output swam_pkg::swam_ctl_type             s1_ctl,
   output logic [$clog2(ALPHABET + 1)-1:0]    s1_new_bin,
   output logic [$clog2(ALPHABET + 1)-1:0]    s1_old_bin
);

   localparam int BIN_W  = $clog2(ALPHABET + 1);
   localparam int CNT_W  = $clog2(MAX_PATTERN + 1);
   localparam int RING_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   logic [CNT_W-1:0]       plen_ff, plen_in;
   logic [CNT_W-1:0]       fill_ff, fill_in;
   logic [RING_W-1:0]      ring_ff, ring_in;
   logic                   ovf_ff, ovf_in;
   logic                   s1_valid_ff, s1_valid_in;
   swam_pkg::swam_ctl_type s1_ctl_ff, ctl_in;
   logic [BIN_W-1:0]       s1_bin_ff, bin_in;

   logic [6:0]             letter_off;
   logic                   is_letter;
   logic [CNT_W:0]         ring_x, plen_x, back_x, fill_next_x;
   logic [RING_W-1:0]      old_idx;
   logic [RING_W-1:0]      ring_next;
   logic                   wr_en;

   // Letter code to bin; anything outside the alphabet goes to the extra bin.
   assign letter_off = letter - 7'(swam_pkg::LETTER_BASE);
   assign is_letter  = (letter >= 7'(swam_pkg::LETTER_BASE)) && (int'(letter_off) < ALPHABET);
   assign bin_in     = is_letter ? BIN_W'(letter_off) : BIN_W'(ALPHABET);

   // Ring slot of the oldest window letter, and the advanced ring pointer.
   assign ring_x      = (CNT_W + 1)'(ring_ff);
   assign plen_x      = (CNT_W + 1)'(plen_ff);
   assign back_x      = (ring_x >= plen_x) ? (ring_x - plen_x)
                                           : (ring_x + (CNT_W + 1)'(MAX_PATTERN) - plen_x);
   assign old_idx     = back_x[RING_W-1:0];
   assign ring_next   = ((CNT_W + 1)'(ring_ff) + 1'b1 == (CNT_W + 1)'(MAX_PATTERN))
                        ? '0 : ring_ff + 1'b1;
   assign fill_next_x = (CNT_W + 1)'(fill_ff) + 1'b1;

   // Decode of the incoming word.
   always_comb begin
      plen_in = plen_ff;
      fill_in = fill_ff;
      ring_in = ring_ff;
      ovf_in  = ovf_ff;
      ctl_in  = '0;
      wr_en   = 1'b0;
      unique case (opcode)
         swam_pkg::OP_CLEAR: begin
            plen_in      = '0;
            fill_in      = '0;
            ring_in      = '0;
            ovf_in       = 1'b0;
            ctl_in.clear = 1'b1;
         end
         swam_pkg::OP_PATTERN: begin
            if (is_letter) begin
               if (plen_ff == CNT_W'(MAX_PATTERN)) begin
                  ovf_in = 1'b1;
               end else begin
                  plen_in        = plen_ff + 1'b1;
                  ctl_in.pat_add = 1'b1;
               end
            end
         end
         swam_pkg::OP_TEXT: begin
            ctl_in.text     = 1'b1;
            ctl_in.last     = last;
            ctl_in.overflow = ovf_ff;
            if (plen_ff == '0) begin
               ctl_in.full = 1'b1;
            end else begin
               ctl_in.keep = 1'b1;
               wr_en       = 1'b1;
               ring_in     = ring_next;
               if (fill_ff == plen_ff) begin
                  ctl_in.remove = 1'b1;
                  ctl_in.full   = 1'b1;
               end else begin
                  fill_in     = fill_ff + 1'b1;
                  ctl_in.full = (fill_next_x == plen_x);
               end
            end
         end
         default: begin
         end
      endcase
   end

   // The stage register fills on accept and empties when the next stage takes it.
   assign s1_valid_in = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff     <= '0;
         fill_ff     <= '0;
         ring_ff     <= '0;
         ovf_ff      <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (accept) begin
            plen_ff <= plen_in;
            fill_ff <= fill_in;
            ring_ff <= ring_in;
            ovf_ff  <= ovf_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ctl_ff <= ctl_in;
         s1_bin_ff <= bin_in;
      end
   end

   // Ring of recent text letters; the oldest letter is read as the new one is written.
   swam_ram #(
      .WIDTH (BIN_W),
      .DEPTH (MAX_PATTERN)
   ) u_ring (
      .clock   (clock),
      .wr_en   (accept && wr_en),
      .wr_addr (ring_ff),
      .wr_data (bin_in),
      .rd_en   (accept),
      .rd_addr (old_idx),
      .rd_data (s1_old_bin)
   );

   assign s1_valid   = s1_valid_ff;
   assign s1_ctl     = s1_ctl_ff;
   assign s1_new_bin = s1_bin_ff;

endmodule

// ----- rtl/swam_bins.sv -----
// Per-letter pattern and window counts, one cell per bin, and the all-bins-equal test.
module swam_bins #(
   parameter int MAX_PATTERN = swam_pkg::MAX_PATTERN_DEF,
   parameter int ALPHABET    = swam_pkg::ALPHABET_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step,
   input  swam_pkg::swam_ctl_type          ctl,
   input  logic [$clog2(ALPHABET + 1)-1:0] new_bin,
   input  logic [$clog2(ALPHABET + 1)-1:0] old_bin,
   output logic                            all_eq_next
);

   localparam int BINS  = ALPHABET + 1;
   localparam int BIN_W = $clog2(ALPHABET + 1);
   localparam int CNT_W = $clog2(MAX_PATTERN + 1);

   logic [CNT_W-1:0] p_cnt_ff [BINS];
   logic [CNT_W-1:0] w_cnt_ff [BINS];
   logic [CNT_W-1:0] p_cnt_in [BINS];
   logic [CNT_W-1:0] w_cnt_in [BINS];
   logic [BINS-1:0]  eq_next;

   // Each cell updates only itself: the new letter adds, the leaving letter takes away.
   always_comb begin
      for (int i = 0; i < BINS; i++) begin
         logic inc_p;
         logic inc_w;
         logic dec_w;
         inc_p = ctl.pat_add && (new_bin == BIN_W'(i));
         inc_w = ctl.keep && (new_bin == BIN_W'(i));
         dec_w = ctl.remove && (old_bin == BIN_W'(i)) && (w_cnt_ff[i] != '0);
         p_cnt_in[i] = inc_p ? p_cnt_ff[i] + 1'b1 : p_cnt_ff[i];
         case ({inc_w, dec_w})
            2'b10:   w_cnt_in[i] = w_cnt_ff[i] + 1'b1;
            2'b01:   w_cnt_in[i] = w_cnt_ff[i] - 1'b1;
            default: w_cnt_in[i] = w_cnt_ff[i];
         endcase
         eq_next[i] = (p_cnt_in[i] == w_cnt_in[i]);
      end
   end

   assign all_eq_next = &eq_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BINS; i++) begin
            p_cnt_ff[i] <= '0;
            w_cnt_ff[i] <= '0;
         end
      end else if (step) begin
         for (int i = 0; i < BINS; i++) begin
            p_cnt_ff[i] <= ctl.clear ? '0 : p_cnt_in[i];
            w_cnt_ff[i] <= ctl.clear ? '0 : w_cnt_in[i];
         end
      end
   end

endmodule

// ----- rtl/sliding_window_anagram_match.sv -----
// Top level of the streaming sliding-window anagram search.
//
// Send a clear word, then the pattern letters, then the text letters. Every
// text word yields one result word; clear, pattern and unused opcode words
// yield none. The block takes one word per clock while req_stall is low.
// The edge that accepts a text word updates lengths and the ring pointer
// and starts the read of the oldest window letter from the ring RAM. From
// the front stage register the match is judged, and the edge that moves the
// word on updates the per-letter counts and loads the result into the output
// register. Results wait in that output register, and req_stall rises only
// when that register is full and stalled with a text word behind it. The
// ring holds MAX_PATTERN letters and needs no clearing after reset.
// Pattern letters past MAX_PATTERN are dropped and raise rsp_pattern_too_long
// until the next clear.
module sliding_window_anagram_match #(
   parameter int MAX_PATTERN = swam_pkg::MAX_PATTERN_DEF,
   parameter int ALPHABET    = swam_pkg::ALPHABET_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_opcode,
   input  logic [6:0] req_letter,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_window_match,
   output logic       rsp_found,
   output logic       rsp_end_of_text,
   output logic       rsp_pattern_too_long
);

   localparam int BIN_W = $clog2(ALPHABET + 1);

   logic                   accept;
   logic                   s1_valid;
   logic                   s1_go;
   swam_pkg::swam_ctl_type s1_ctl;
   logic [BIN_W-1:0]       s1_new_bin;
   logic [BIN_W-1:0]       s1_old_bin;
   logic                   all_eq_next;
   logic                   match;

   logic rsp_valid_ff, rsp_valid_in;
   logic found_ff, found_in;
   logic match_ff, rsp_found_ff, eot_ff, too_long_ff;

   // The staged word moves on unless it is a text word and the result register is blocked.
   assign s1_go     = s1_valid && (!s1_ctl.text || !rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid && !s1_go;
   assign accept    = req_valid && !req_stall;

   swam_front #(
      .MAX_PATTERN (MAX_PATTERN),
      .ALPHABET    (ALPHABET)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .opcode     (req_opcode),
      .letter     (req_letter),
      .last       (req_last),
      .advance    (s1_go),
      .s1_valid   (s1_valid),
      .s1_ctl     (s1_ctl),
      .s1_new_bin (s1_new_bin),
      .s1_old_bin (s1_old_bin)
   );

   swam_bins #(
      .MAX_PATTERN (MAX_PATTERN),
      .ALPHABET    (ALPHABET)
   ) u_bins (
      .clock       (clock),
      .reset       (reset),
      .step        (s1_go),
      .ctl         (s1_ctl),
      .new_bin     (s1_new_bin),
      .old_bin     (s1_old_bin),
      .all_eq_next (all_eq_next)
   );

   // Match and sticky found flag for the word now leaving the front stage.
   assign match    = s1_ctl.full && all_eq_next;
   assign found_in = s1_ctl.clear ? 1'b0 : (found_ff || (s1_ctl.text && match));

   assign rsp_valid_in = (s1_go && s1_ctl.text) ? 1'b1
                                                : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (s1_go) begin
            found_ff <= found_in;
         end
      end
   end

   // Result payload loads only when a text word moves into the output register.
   always_ff @(posedge clock) begin
      if (s1_go && s1_ctl.text) begin
         match_ff     <= match;
         rsp_found_ff <= found_in;
         eot_ff       <= s1_ctl.last;
         too_long_ff  <= s1_ctl.overflow;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_window_match     = match_ff;
   assign rsp_found            = rsp_found_ff;
   assign rsp_end_of_text      = eot_ff;
   assign rsp_pattern_too_long = too_long_ff;

endmodule

// ----- rtl/swam_checker.sv -----
// Port-level checker of the anagram search block and its bind to the top level.
`include "sliding_window_anagram_match_defines.svh"

module swam_checker (
   input logic clock,
   input logic reset,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_window_match,
   input logic rsp_found,
   input logic rsp_end_of_text,
   input logic rsp_pattern_too_long
);

   // A stalled result word keeps its valid and every field.
   `SWAM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_window_match) && $stable(rsp_found)
         && $stable(rsp_end_of_text) && $stable(rsp_pattern_too_long),
      "stalled result word changed")

   // A matching window always shows up in the sticky found flag of the same word.
   `SWAM_ASSERT_IMPL(a_match_found, clock, reset, rsp_valid && rsp_window_match,
      rsp_found, "window match without found flag")

   // Reset leaves no result word pending.
   `SWAM_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid,
      "result word valid right after reset")

   // The input is never stalled while no result word is pending.
   `SWAM_ASSERT_IMPL(a_no_stall_idle, clock, reset, !rsp_valid,
      !req_stall, "input stalled while no result is pending")

endmodule

bind sliding_window_anagram_match swam_checker u_swam_checker (
   .clock                (clock),
   .reset                (reset),
   .req_stall            (req_stall),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_window_match     (rsp_window_match),
   .rsp_found            (rsp_found),
   .rsp_end_of_text      (rsp_end_of_text),
   .rsp_pattern_too_long (rsp_pattern_too_long)
);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the sliding-window anagram search block.
module tb_top;

   // Opcode that the block ignores.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam int RING_DEPTH   = swam_pkg::MAX_PATTERN_DEF;
   localparam int OTHER_BIN    = swam_pkg::ALPHABET_DEF;
   localparam int RANDOM_WORDS = 900;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 8;

   typedef struct packed {
      logic [1:0] opcode;
      logic [6:0] letter;
      logic       last;
   } req_word_type;

   typedef struct packed {
      logic window_match;
      logic found;
      logic end_of_text;
      logic pattern_too_long;
   } rsp_word_type;

   typedef logic [6:0] letter_q_type[$];

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_opcode = swam_pkg::OP_CLEAR;
   logic [6:0] req_letter = '0;
   logic       req_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_window_match;
   logic       rsp_found;
   logic       rsp_end_of_text;
   logic       rsp_pattern_too_long;

   // Long receiver hold-off, raised by its own process.
   logic hold_off = 1'b0;

   sliding_window_anagram_match DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_opcode           (req_opcode),
      .req_letter           (req_letter),
      .req_last             (req_last),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_window_match     (rsp_window_match),
      .rsp_found            (rsp_found),
      .rsp_end_of_text      (rsp_end_of_text),
      .rsp_pattern_too_long (rsp_pattern_too_long)
   );

   always #5 clock = ~clock;

   // Stimulus and expectation stores, run counters.
   req_word_type pending_words[$];
   rsp_word_type awaited_results[$];
   int words_built   = 0;
   int words_sent    = 0;
   int results_seen  = 0;
   int matches_seen  = 0;
   int overflow_seen = 0;
   int input_stalls  = 0;
   int mismatches    = 0;

   // Predictor state of the search.
   logic [12:0] pat_bins [0:swam_pkg::ALPHABET_DEF];
   logic [12:0] win_bins [0:swam_pkg::ALPHABET_DEF];
   logic [4:0]  diff_bins;
   logic [12:0] pat_len;
   logic [12:0] win_fill;
   logic [4:0]  ring [0:RING_DEPTH-1];
   logic [11:0] ring_pos;
   logic        found_q;
   logic        overflow_q;

   function automatic void clear_search();
      for (int b = 0; b <= swam_pkg::ALPHABET_DEF; b++) begin
         pat_bins[b] = '0;
         win_bins[b] = '0;
      end
      diff_bins  = '0;
      pat_len    = '0;
      win_fill   = '0;
      ring_pos   = '0;
      found_q    = 1'b0;
      overflow_q = 1'b0;
   endfunction

   function automatic int letter_bin(logic [6:0] code);
      if (code >= swam_pkg::LETTER_BASE
          && code < swam_pkg::LETTER_BASE + swam_pkg::ALPHABET_DEF)
         return int'(code) - swam_pkg::LETTER_BASE;
      return OTHER_BIN;
   endfunction

   // Write one count bin and keep the number of differing bins in step.
   function automatic void set_bin(bit to_pattern, int b, logic [12:0] v);
      bit was_diff;
      bit now_diff;
      was_diff = pat_bins[b] != win_bins[b];
      if (to_pattern)
         pat_bins[b] = v;
      else
         win_bins[b] = v;
      now_diff = pat_bins[b] != win_bins[b];
      if (was_diff && !now_diff)
         diff_bins = diff_bins - 5'd1;
      else if (!was_diff && now_diff)
         diff_bins = diff_bins + 5'd1;
   endfunction

   // Advance the search by one accepted word; text words leave an expected result.
   function automatic void anagram_step(req_word_type w);
      int b;
      int old_b;
      logic [11:0] idx;
      logic hit;
      rsp_word_type r;
      b = letter_bin(w.letter);
      case (w.opcode)
         swam_pkg::OP_CLEAR: begin
            clear_search();
         end
         swam_pkg::OP_PATTERN: begin
            if (b != OTHER_BIN) begin
               if (pat_len >= RING_DEPTH) begin
                  overflow_q = 1'b1;
               end else begin
                  pat_len = pat_len + 13'd1;
                  set_bin(1'b1, b, pat_bins[b] + 13'd1);
               end
            end
         end
         swam_pkg::OP_TEXT: begin
            // An empty pattern keeps no letters at all.
            if (pat_len != 0) begin
               if (win_fill >= pat_len) begin
                  idx = ring_pos - pat_len[11:0];
                  old_b = int'(ring[idx]);
                  if (win_bins[old_b] != 0)
                     set_bin(1'b0, old_b, win_bins[old_b] - 13'd1);
                  win_fill = pat_len;
               end else begin
                  win_fill = win_fill + 13'd1;
               end
               ring[ring_pos] = b[4:0];
               ring_pos = ring_pos + 12'd1;
               set_bin(1'b0, b, win_bins[b] + 13'd1);
            end
            hit = (win_fill == pat_len) && (diff_bins == 0);
            if (hit)
               found_q = 1'b1;
            r.window_match     = hit;
            r.found            = found_q;
            r.end_of_text      = w.last;
            r.pattern_too_long = overflow_q;
            awaited_results.push_back(r);
         end
         default: begin
         end
      endcase
   endfunction

   // Random idle length: mostly none, some short, a few long, with idle-free runs.
   function automatic int pick_gap(inout int steady);
      int r;
      if (steady > 0) begin
         steady--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         steady = $urandom_range(40, 160);
         return 0;
      end
      if (r < 62)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void push_word(logic [1:0] op, logic [6:0] code, logic tail);
      req_word_type w;
      w.opcode = op;
      w.letter = code;
      w.last   = tail;
      pending_words.push_back(w);
      // Words the block drops unseen do not count toward the random volume.
      if (op != OP_UNUSED
          && !(op == swam_pkg::OP_PATTERN && letter_bin(code) == OTHER_BIN))
         words_built++;
   endfunction

   // Any 7-bit code outside the lowercase letters.
   function automatic logic [6:0] odd_code();
      int r;
      r = $urandom_range(0, 127 - swam_pkg::ALPHABET_DEF);
      return 7'((r < swam_pkg::LETTER_BASE) ? r : r + swam_pkg::ALPHABET_DEF);
   endfunction

   function automatic letter_q_type shuffled(letter_q_type q);
      letter_q_type s;
      logic [6:0] t;
      int j;
      s = q;
      for (int i = s.size() - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         t = s[i];
         s[i] = s[j];
         s[j] = t;
      end
      return s;
   endfunction

   // One search session: mostly a clear, a pattern and a text rich in anagrams.
   function automatic void add_session();
      letter_q_type pat;
      letter_q_type chunk;
      int plen;
      int span;
      int tlen;
      int r;
      logic [6:0] ch;
      r = $urandom_range(0, 99);
      if (r < 6)
         plen = 0;
      else if (r < 80)
         plen = $urandom_range(1, 6);
      else
         plen = $urandom_range(7, 30);
      span = $urandom_range(2, swam_pkg::ALPHABET_DEF);
      if ($urandom_range(0, 99) < 85)
         push_word(swam_pkg::OP_CLEAR, 7'($urandom), 1'($urandom));
      for (int i = 0; i < plen; i++) begin
         ch = 7'(swam_pkg::LETTER_BASE + $urandom_range(0, span - 1));
         pat.push_back(ch);
         push_word(swam_pkg::OP_PATTERN, ch,
                   (i == plen - 1) ? 1'b1 : 1'($urandom_range(0, 9) == 0));
         if ($urandom_range(0, 99) < 3)
            push_word(swam_pkg::OP_PATTERN, odd_code(), 1'($urandom));
      end
      tlen = $urandom_range(4, 40);
      for (int i = 0; i < tlen; i++) begin
         r = $urandom_range(0, 99);
         if (r < 25 && pat.size() != 0) begin
            chunk = shuffled(pat);
            foreach (chunk[j])
               push_word(swam_pkg::OP_TEXT, chunk[j], 1'b0);
         end else if (r < 29) begin
            push_word(swam_pkg::OP_TEXT, odd_code(), 1'($urandom));
         end else if (r < 31) begin
            push_word(OP_UNUSED, 7'($urandom), 1'($urandom));
         end else if (r < 33) begin
            // The pattern grows in the middle of the text.
            ch = 7'(swam_pkg::LETTER_BASE + $urandom_range(0, span - 1));
            pat.push_back(ch);
            push_word(swam_pkg::OP_PATTERN, ch, 1'($urandom));
         end else begin
            push_word(swam_pkg::OP_TEXT,
                      7'(swam_pkg::LETTER_BASE + $urandom_range(0, span - 1)),
                      1'($urandom_range(0, 19) == 0));
         end
      end
      push_word(swam_pkg::OP_TEXT,
                7'(swam_pkg::LETTER_BASE + $urandom_range(0, span - 1)), 1'b1);
   endfunction

   // Driver: presents queued words, holds a stalled word, inserts random gaps.
   int           gap_left  = 0;
   int           tx_steady = 0;
   req_word_type sent_word;
   req_word_type next_word;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
         clear_search();
      end else begin
         if (req_valid && !req_stall) begin
            sent_word = {req_opcode, req_letter, req_last};
            anagram_step(sent_word);
            words_sent++;
         end
         if (req_valid && req_stall)
            input_stalls++;
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0 && !hold_off) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               next_word = pending_words.pop_front();
               req_valid  <= 1'b1;
               req_opcode <= next_word.opcode;
               req_letter <= next_word.letter;
               req_last   <= next_word.last;
               gap_left = pick_gap(tx_steady);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   function automatic void check_field(string name, logic want, logic got);
      if (got !== want) begin
         $error("%s: expected %0b, got %0b", name, want, got);
         mismatches++;
      end
   endfunction

   // Monitor: checks each accepted result word and drives random receiver stalls.
   int           stall_left = 0;
   int           rx_steady  = 0;
   rsp_word_type want_rsp;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               $error("Result word arrived with no expectation waiting.");
               mismatches++;
            end else begin
               want_rsp = awaited_results.pop_front();
               check_field("window_match", want_rsp.window_match, rsp_window_match);
               check_field("found", want_rsp.found, rsp_found);
               check_field("end_of_text", want_rsp.end_of_text, rsp_end_of_text);
               check_field("pattern_too_long", want_rsp.pattern_too_long,
                           rsp_pattern_too_long);
               results_seen++;
               if (rsp_window_match)
                  matches_seen++;
               if (rsp_pattern_too_long)
                  overflow_seen++;
            end
         end
         if (hold_off) begin
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = pick_gap(rx_steady);
         end
      end
   end

   // Long receiver hold-off so the block fills up and stalls its input.
   initial begin
      wait (words_sent >= 300);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   // Stimulus build, reset, and end of run.
   initial begin
      int base;
      // Empty pattern: every text word matches, non-letters too.
      push_word(swam_pkg::OP_CLEAR, 7'd0, 1'b1);
      push_word(swam_pkg::OP_TEXT, 7'd97, 1'b0);
      push_word(swam_pkg::OP_TEXT, 7'd127, 1'b1);
      push_word(OP_UNUSED, 7'd113, 1'b0);
      // Non-letter pattern codes are ignored.
      push_word(swam_pkg::OP_CLEAR, 7'd85, 1'b0);
      push_word(swam_pkg::OP_PATTERN, 7'd0, 1'b0);
      push_word(swam_pkg::OP_PATTERN, 7'd127, 1'b1);
      push_word(swam_pkg::OP_PATTERN, 7'd96, 1'b0);
      push_word(swam_pkg::OP_PATTERN, 7'd123, 1'b0);
      // Pattern of the two extreme letters, then text around it.
      push_word(swam_pkg::OP_PATTERN, 7'd97, 1'b0);
      push_word(swam_pkg::OP_PATTERN, 7'd122, 1'b1);
      push_word(swam_pkg::OP_TEXT, 7'd122, 1'b0);
      push_word(swam_pkg::OP_TEXT, 7'd97, 1'b0);
      push_word(swam_pkg::OP_TEXT, 7'd127, 1'b0);
      push_word(swam_pkg::OP_TEXT, 7'd122, 1'b0);
      push_word(swam_pkg::OP_TEXT, 7'd97, 1'b1);
      // Pattern grows after text, the window grows with it.
      push_word(swam_pkg::OP_PATTERN, 7'd98, 1'b0);
      push_word(swam_pkg::OP_TEXT, 7'd98, 1'b0);
      push_word(OP_UNUSED, 7'd127, 1'b1);
      push_word(swam_pkg::OP_TEXT, 7'd97, 1'b0);
      push_word(swam_pkg::OP_TEXT, 7'd0, 1'b1);
      // Clear drops the found flag.
      push_word(swam_pkg::OP_CLEAR, 7'd127, 1'b1);
      push_word(swam_pkg::OP_TEXT, 7'd122, 1'b0);

      base = words_built;
      while (words_built - base < RANDOM_WORDS)
         add_session();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (pending_words.size() != 0 || req_valid || awaited_results.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d input words and %0d checked result words (%0d matches).",
               words_sent, results_seen, matches_seen);
      $display("Input was held off for %0d cycles; %0d results carried the overflow flag.",
               input_stalls, overflow_seen);
      if (mismatches == 0 && awaited_results.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // Timeout far beyond the slowest correct run.
   initial begin
      #(64'd50_000_000);
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ----- sliding_window_anagram_match.f -----
+incdir+rtl
rtl/swam_pkg.sv
rtl/swam_ram.sv
rtl/swam_front.sv
rtl/swam_bins.sv
rtl/sliding_window_anagram_match.sv
rtl/swam_checker.sv
tb/sv/tb_top.sv
